/* sv/tspe_pkg.sv */
// ----------------------------------------------------------------------------
// tspe_pkg: shared types and constants of the transport stream re-framer
// Packet layout constants, sync words, register map and the per-item
// emission descriptor passed from the parser to the output sequencer.
// ----------------------------------------------------------------------------
package tspe_pkg;

  // packet layout
  localparam int PACKET_BYTES = 188;
  localparam logic [7:0] PAYLOAD_END  = 8'd188;
  localparam logic [7:0] NO_OFFSET    = 8'd255;
  localparam logic [7:0] POS_MAX      = 8'd255;
  localparam logic [7:0] ADAPT_LEN_MAX = 8'd182;
  localparam logic [12:0] COUNT_MAX   = 13'd8191;

  // adaptation field control codes
  localparam logic [1:0] AFC_ADAPT_ONLY = 2'd2;
  localparam logic [1:0] AFC_ADAPT_PAY  = 2'd3;

  // sync words, entry 0 goes out first
  localparam logic [3:0][7:0] SYNC_EVEN = {8'hB6, 8'h3A, 8'h07, 8'hFF};
  localparam logic [3:0][7:0] SYNC_ODD  = {8'h49, 8'hC5, 8'hF8, 8'hFF};

  // register map (word index)
  localparam logic [1:0] REG_WANTED_PID = 2'd0;
  localparam logic [1:0] REG_FRAME_LEN  = 2'd1;
  localparam logic [1:0] REG_FILL_BYTE  = 2'd2;

  localparam logic [12:0] WANTED_PID_RST = 13'd0;
  localparam logic [12:0] FRAME_LEN_RST  = 13'd6140;
  localparam logic [7:0]  FILL_BYTE_RST  = 8'h55;

  // descriptor queue depth
  localparam int DESC_DEPTH = 4;
  localparam int DESC_AW    = $clog2(DESC_DEPTH);

  // emission steps of one descriptor
  typedef enum logic [2:0] {
    STEP_FILL  = 3'd0,
    STEP_SYNC0 = 3'd1,
    STEP_SYNC1 = 3'd2,
    STEP_SYNC2 = 3'd3,
    STEP_SYNC3 = 3'd4,
    STEP_PAY   = 3'd5
  } step_t;

  // results caused by one accepted byte
  typedef struct packed {
    logic        fill_en;
    logic [12:0] fill_len;
    logic [7:0]  fill_byte;
    logic        sync_en;
    logic        sync_odd;
    logic        pay_en;
    logic [7:0]  pay_byte;
  } desc_t;

endpackage

/* sv/ts_pid_payload_to_eti_frames.sv */
// ----------------------------------------------------------------------------
// ts_pid_payload_to_eti_frames: PID filter and fixed-length frame builder
// Usage: transport stream bytes enter on the in_ stream, one byte per
// transfer, in_tuser high on the first byte of each packet. The payload of
// packets with the configured PID is re-framed: at each payload-unit-start
// a fill run closes the previous frame, then a 4-byte sync word follows,
// then the payload bytes. Each out_ transfer carries one byte and a repeat
// count (above 1 only for fill runs); out_tlast marks the last result
// caused by one input byte.
// Throughput: one input byte per cycle while each byte gives at most one
// result and the receiver is ready; a frame start gives up to six results,
// sent one per cycle by the output sequencer while the receiver is ready,
// and a four-entry descriptor queue absorbs these bursts. With the queue
// empty a result passes through a queue entry and then the output register.
// A stalled receiver holds the output register; the queue fills and then
// in_tready drops. Reset clears all packet and frame state and loads the
// register defaults (PID 0, 6140 bytes per frame, fill 0x55).
// Registers over APB: 0x0 wanted PID, 0x4 frame payload bytes, 0x8 fill byte.
// ----------------------------------------------------------------------------
module ts_pid_payload_to_eti_frames (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] packet_first
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_byte, [20:8] repeat_count, zero above
  output logic        out_tlast,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import tspe_pkg::*;

  logic [12:0] wanted_pid_r;
  logic [12:0] frame_len_r;
  logic [7:0]  fill_byte_r;
  logic        cfg_wr;
  logic        accept;
  logic        push, pop, full, head_valid;
  desc_t       push_desc, head;
  logic [7:0]  res_byte;
  logic [12:0] res_repeat;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_pid_r <= WANTED_PID_RST;
      frame_len_r  <= FRAME_LEN_RST;
      fill_byte_r  <= FILL_BYTE_RST;
    end else if (cfg_wr && cfg_paddr[1:0] == 2'd0) begin
      unique case (cfg_paddr[3:2])
        REG_WANTED_PID: wanted_pid_r <= cfg_pwdata[12:0];
        REG_FRAME_LEN:  frame_len_r  <= cfg_pwdata[12:0];
        REG_FILL_BYTE:  fill_byte_r  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_WANTED_PID: cfg_prdata = {19'd0, wanted_pid_r};
      REG_FRAME_LEN:  cfg_prdata = {19'd0, frame_len_r};
      REG_FILL_BYTE:  cfg_prdata = {24'd0, fill_byte_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // input transfer
  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  tspe_parser u_parser (
    .clk                 (clk),
    .rst_n               (rst_n),
    .accept              (accept),
    .data_byte           (in_tdata),
    .packet_first        (in_tuser),
    .wanted_pid          (wanted_pid_r),
    .frame_payload_bytes (frame_len_r),
    .fill_byte           (fill_byte_r),
    .push                (push),
    .desc                (push_desc)
  );

  tspe_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  tspe_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (res_byte),
    .out_repeat (res_repeat),
    .out_last   (out_tlast)
  );

  assign out_tdata = {3'd0, res_repeat, res_byte};

endmodule

/* sv/tspe_parser.sv */
// ----------------------------------------------------------------------------
// tspe_parser: packet header parser, PID filter and frame accounting
// Works on one byte per cycle while accept is high and describes its results.
// ----------------------------------------------------------------------------
module tspe_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               packet_first,
  input  logic [12:0]        wanted_pid,
  input  logic [12:0]        frame_payload_bytes,
  input  logic [7:0]         fill_byte,
  output logic               push,
  output tspe_pkg::desc_t    desc
);
  import tspe_pkg::*;

  logic [7:0]  pos_r, pos_nxt;
  logic [4:0]  pid_high_r, pid_high_nxt;
  logic        uss_r, uss_nxt;
  logic        sel_r, sel_nxt;
  logic [1:0]  afc_r, afc_nxt;
  logic [7:0]  off_r, off_nxt;
  logic        active_r, active_nxt;
  logic [12:0] count_r, count_nxt;
  logic [7:0]  p;

  // effective position of this byte
  assign p = packet_first ? 8'd0 : pos_r;

  // header decode and frame accounting
  always_comb begin
    pos_nxt      = pos_r;
    pid_high_nxt = pid_high_r;
    uss_nxt      = uss_r;
    sel_nxt      = sel_r;
    afc_nxt      = afc_r;
    off_nxt      = off_r;
    active_nxt   = active_r;
    count_nxt    = count_r;
    push         = 1'b0;
    desc         = '0;
    desc.fill_byte = fill_byte;
    desc.pay_byte  = data_byte;
    desc.sync_odd  = data_byte[0];
    if (accept) begin
      pos_nxt = (p < POS_MAX) ? p + 8'd1 : POS_MAX;
      if (p < 8'(PACKET_BYTES)) begin
        priority if (p == 8'd0) begin
          sel_nxt = 1'b0;
        end else if (p == 8'd1) begin
          pid_high_nxt = data_byte[4:0];
          uss_nxt      = data_byte[6];
          sel_nxt      = 1'b0;
        end else if (p == 8'd2) begin
          sel_nxt = ({pid_high_r, data_byte} == wanted_pid);
        end else if (p == 8'd3) begin
          afc_nxt = data_byte[5:4];
          if (data_byte[5:4] == AFC_ADAPT_ONLY) sel_nxt = 1'b0;
          off_nxt = (data_byte[5:4] == AFC_ADAPT_PAY) ? NO_OFFSET
                                                      : 8'd4 + {7'd0, uss_r};
        end else if (p == 8'd4 && afc_r == AFC_ADAPT_PAY) begin
          if (data_byte > ADAPT_LEN_MAX) sel_nxt = 1'b0;
          else off_nxt = 8'd5 + data_byte + {7'd0, uss_r};
        end else if (sel_r && p >= off_r && p < PAYLOAD_END) begin
          // frame start: pad out the previous frame, then a sync word
          if (uss_r && p == off_r) begin
            desc.fill_en  = active_r && (frame_payload_bytes > count_r);
            desc.fill_len = frame_payload_bytes - count_r;
            desc.sync_en  = 1'b1;
            active_nxt    = 1'b1;
            count_nxt     = 13'd1;
          end else if (count_r < COUNT_MAX) begin
            count_nxt = count_r + 13'd1;
          end
          desc.pay_en = active_nxt;
          push        = active_nxt;
        end else begin
          // adaptation field, pointer byte or a dropped packet: nothing to do
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      pid_high_r <= '0;
      uss_r      <= 1'b0;
      sel_r      <= 1'b0;
      afc_r      <= '0;
      off_r      <= '0;
      active_r   <= 1'b0;
      count_r    <= '0;
    end else begin
      pos_r      <= pos_nxt;
      pid_high_r <= pid_high_nxt;
      uss_r      <= uss_nxt;
      sel_r      <= sel_nxt;
      afc_r      <= afc_nxt;
      off_r      <= off_nxt;
      active_r   <= active_nxt;
      count_r    <= count_nxt;
    end
  end

endmodule

/* sv/tspe_fifo.sv */
// ----------------------------------------------------------------------------
// tspe_fifo: small descriptor queue
// Decouples the byte-rate parser from the multi-cycle output sequencer.
// ----------------------------------------------------------------------------
module tspe_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tspe_pkg::desc_t    push_desc,
  input  logic               pop,
  output logic               full,
  output logic               head_valid,
  output tspe_pkg::desc_t    head
);
  import tspe_pkg::*;

  desc_t                entry_r [DESC_DEPTH];
  logic [DESC_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [DESC_AW:0]     cnt_r, cnt_nxt;

  assign full       = (cnt_r == (DESC_AW+1)'(DESC_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = entry_r[rd_ptr_r];

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_desc;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop)) else $error("descriptor queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("descriptor queue underflow");

endmodule

/* sv/tspe_emitter.sv */
// ----------------------------------------------------------------------------
// tspe_emitter: output sequencer
// Expands each descriptor into fill, sync and payload results, one per
// cycle while the receiver is ready, into a registered output stage.
// ----------------------------------------------------------------------------
module tspe_emitter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  tspe_pkg::desc_t    head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic [12:0]        out_repeat,
  output logic               out_last
);
  import tspe_pkg::*;

  logic        busy_r, busy_nxt;
  step_t       step_r, step_nxt, cur;
  logic        valid_r, valid_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [12:0] rep_r, rep_nxt;
  logic        last_r, last_nxt;
  logic        load;
  logic        cur_last;

  assign out_valid  = valid_r;
  assign out_byte   = byte_r;
  assign out_repeat = rep_r;
  assign out_last   = last_r;

  // output stage free for a new result
  assign load = head_valid && (!valid_r || out_ready);

  // step of the head descriptor to send now
  always_comb begin
    if (busy_r) cur = step_r;
    else if (head.fill_en) cur = STEP_FILL;
    else if (head.sync_en) cur = STEP_SYNC0;
    else cur = STEP_PAY;
  end

  assign cur_last = (cur == STEP_PAY);
  assign pop      = load && cur_last;

  // result selection
  always_comb begin
    byte_nxt = head.pay_byte;
    rep_nxt  = 13'd1;
    step_nxt = STEP_PAY;
    unique case (cur)
      STEP_FILL: begin
        byte_nxt = head.fill_byte;
        rep_nxt  = head.fill_len;
        step_nxt = STEP_SYNC0;
      end
      STEP_SYNC0: begin
        byte_nxt = head.sync_odd ? SYNC_ODD[0] : SYNC_EVEN[0];
        step_nxt = STEP_SYNC1;
      end
      STEP_SYNC1: begin
        byte_nxt = head.sync_odd ? SYNC_ODD[1] : SYNC_EVEN[1];
        step_nxt = STEP_SYNC2;
      end
      STEP_SYNC2: begin
        byte_nxt = head.sync_odd ? SYNC_ODD[2] : SYNC_EVEN[2];
        step_nxt = STEP_SYNC3;
      end
      STEP_SYNC3: begin
        byte_nxt = head.sync_odd ? SYNC_ODD[3] : SYNC_EVEN[3];
        step_nxt = STEP_PAY;
      end
      STEP_PAY: begin
        byte_nxt = head.pay_byte;
        step_nxt = STEP_PAY;
      end
      default: begin
        byte_nxt = head.pay_byte;
        step_nxt = STEP_PAY;
      end
    endcase
    last_nxt = cur_last;
  end

  // output valid and sequencing control
  always_comb begin
    valid_nxt = valid_r;
    busy_nxt  = busy_r;
    if (load) begin
      valid_nxt = 1'b1;
      busy_nxt  = !cur_last;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      busy_r  <= 1'b0;
      step_r  <= STEP_FILL;
    end else begin
      valid_r <= valid_nxt;
      busy_r  <= busy_nxt;
      if (load) step_r <= step_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      rep_r  <= rep_nxt;
      last_r <= last_nxt;
    end
  end

  a_busy_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> head_valid) else $error("sequencer busy without descriptor");
  a_rep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (rep_r != 13'd0)) else $error("zero repeat count on output");

endmodule

/* tb/ts_pid_payload_to_eti_frames_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ts_pid_payload_to_eti_frames_tb: self-checking bench for the PID re-framer
// Feeds short transport stream packets and randomly marked noise bytes through
// the byte stream with bursty valid and a patterned ready. A local model of
// the packet parser and framer predicts every fill, sync and payload
// transfer, and each output transfer is checked field by field. Registers are
// rewritten between phases, including the longest frame length.
// ----------------------------------------------------------------------------
module ts_pid_payload_to_eti_frames_tb;
  import tspe_pkg::*;

  localparam int LIMIT        = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;

  // adaptation control codes not named in the package
  localparam logic [1:0] AFC_RESERVED = 2'd0;
  localparam logic [1:0] AFC_PAY_ONLY = 2'd1;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } ts_byte_t;

  typedef struct packed {
    logic [7:0]  value;
    logic [12:0] reps;
    logic        last;
  } frame_out_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;   // [7:0] data_byte
  logic        in_tuser    = 1'b0; // [0] packet_first
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [23:0] out_tdata;          // [7:0] out_byte, [20:8] repeat_count
  logic        out_tlast;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ts_pid_payload_to_eti_frames uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // stream bytes waiting to go out, and the frame bytes still owed by the block
  ts_byte_t   pending_ts_q[$];
  frame_out_t frame_bytes_q[$];
  int         err_count    = 0;
  logic       hold_request = 1'b0;

  // model copy of registers and parser/framer state
  logic [12:0] model_pid       = WANTED_PID_RST;
  logic [12:0] model_frame_len = FRAME_LEN_RST;
  logic [7:0]  model_fill      = FILL_BYTE_RST;
  logic [7:0]  pkt_pos    = '0;
  logic [4:0]  pid_hi     = '0;
  logic        pusi_seen  = 1'b0;
  logic        pkt_keep   = 1'b0;
  logic [1:0]  afc_mode   = '0;
  logic [7:0]  pay_start  = '0;
  logic        frame_open = 1'b0;
  logic [12:0] frame_cnt  = '0;

  // predict the frame bytes caused by one accepted stream byte
  function automatic void reframe_byte(logic [7:0] b, logic first);
    logic [7:0]      p;
    logic [3:0][7:0] sw;
    frame_out_t      res [6];
    int              n;
    n = 0;
    p = first ? 8'd0 : pkt_pos;
    pkt_pos = (p < POS_MAX) ? p + 8'd1 : POS_MAX;
    if (p < PACKET_BYTES) begin
      if (p == 8'd0) begin
        pkt_keep = 1'b0;
      end else if (p == 8'd1) begin
        pid_hi    = b[4:0];
        pusi_seen = b[6];
        pkt_keep  = 1'b0;
      end else if (p == 8'd2) begin
        pkt_keep = ({pid_hi, b} == model_pid);
      end else if (p == 8'd3) begin
        afc_mode = b[5:4];
        if (afc_mode == AFC_ADAPT_ONLY) pkt_keep = 1'b0;
        pay_start = (afc_mode == AFC_ADAPT_PAY) ? NO_OFFSET : 8'd4 + pusi_seen;
      end else if (p == 8'd4 && afc_mode == AFC_ADAPT_PAY) begin
        if (b > ADAPT_LEN_MAX) pkt_keep = 1'b0;
        else pay_start = 8'd5 + b + pusi_seen;
      end else if (pkt_keep && p >= pay_start && p < PAYLOAD_END) begin
        // frame start: close the old frame with fill, then sync by parity
        if (pusi_seen && p == pay_start) begin
          sw = b[0] ? SYNC_ODD : SYNC_EVEN;
          if (frame_open && model_frame_len > frame_cnt) begin
            res[n] = '{model_fill, model_frame_len - frame_cnt, 1'b0};
            n++;
          end
          frame_open = 1'b1;
          frame_cnt  = '0;
          for (int i = 0; i < 4; i++) begin
            res[n] = '{sw[i], 13'd1, 1'b0};
            n++;
          end
        end
        if (frame_cnt < COUNT_MAX) frame_cnt++;
        if (frame_open) begin
          res[n] = '{b, 13'd1, 1'b0};
          n++;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) res[i].last = 1'b1;
      frame_bytes_q.push_back(res[i]);
    end
  endfunction

  // stimulus building
  function automatic void push_byte(logic [7:0] b, logic first);
    pending_ts_q.push_back('{b, first});
  endfunction

  function automatic void push_header(logic marker, logic [12:0] pid, logic pusi,
                                      logic [1:0] afc);
    logic [7:0] b1, b3;
    b1 = 8'($urandom);
    b1[6] = pusi;
    b1[4:0] = pid[12:8];
    b3 = 8'($urandom);
    b3[5:4] = afc;
    push_byte(($urandom_range(3) == 0) ? 8'($urandom) : 8'h47, marker);
    push_byte(b1, 1'b0);
    push_byte(pid[7:0], 1'b0);
    push_byte(b3, 1'b0);
  endfunction

  // one random packet (mostly well formed, some noise); returns bytes queued
  function automatic int push_random_packet(logic [12:0] pid);
    logic [12:0] p;
    logic        pusi;
    logic [1:0]  afc;
    int          r, alen, hdr, len;
    r = $urandom_range(99);
    if (r < 6) begin
      len = $urandom_range(1, 12);
      repeat (len) push_byte(8'($urandom), $urandom_range(7) == 0);
      return len;
    end
    p    = ($urandom_range(3) == 0) ? 13'($urandom) : pid;
    pusi = ($urandom_range(4) < 2);
    r = $urandom_range(9);
    afc = (r == 0) ? AFC_RESERVED : (r == 1) ? AFC_ADAPT_ONLY :
          (r < 5) ? AFC_ADAPT_PAY : AFC_PAY_ONLY;
    alen = 0;
    if (afc == AFC_ADAPT_PAY) begin
      r = $urandom_range(9);
      alen = (r == 0) ? $urandom_range(183, 255) : $urandom_range(0, 10);
    end
    hdr = 4 + ((afc == AFC_ADAPT_PAY) ? 1 + alen : 0) + pusi;
    if (hdr > PACKET_BYTES) len = $urandom_range(5, 20);
    else len = hdr + $urandom_range(0, 16);
    if (len < 4) len = 4;
    push_header(1'b1, p, pusi, afc);
    for (int i = 4; i < len; i++)
      push_byte((i == 4 && afc == AFC_ADAPT_PAY) ? 8'(alen) : 8'($urandom), 1'b0);
    return len;
  endfunction

  function automatic void push_random_stream(logic [12:0] pid, int target);
    int added;
    added = 0;
    while (added < target) added += push_random_packet(pid);
  endfunction

  // register write: setup then access, register taken at the access edge
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_WANTED_PID: model_pid       = val[12:0];
      REG_FRAME_LEN:  model_frame_len = val[12:0];
      REG_FILL_BYTE:  model_fill      = val[7:0];
      default: ;
    endcase
  endtask

  // wait until every queued byte is sent and every frame byte has arrived
  task automatic wait_drained();
    while (pending_ts_q.size() != 0 || in_tvalid || frame_bytes_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin : sender
    ts_byte_t nxt;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_tvalid && in_tready) reframe_byte(in_tdata, in_tuser);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left  <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_ts_q.size() > 0) begin
          nxt = pending_ts_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.data;
          in_tuser  <= nxt.first;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each transfer and stalls on a rotating pattern
  int unsigned rx_cycle  = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;

  always @(posedge clk) begin : receiver
    frame_out_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (frame_bytes_q.size() == 0) begin
          $error("unexpected transfer: out_byte %02h repeat_count %0d",
                 out_tdata[7:0], out_tdata[20:8]);
          err_count++;
        end else begin
          want = frame_bytes_q.pop_front();
          if (out_tdata[7:0] !== want.value) begin
            $error("out_byte: expected %02h, got %02h", want.value, out_tdata[7:0]);
            err_count++;
          end
          if (out_tdata[20:8] !== want.reps) begin
            $error("repeat_count: expected %0d, got %0d", want.reps, out_tdata[20:8]);
            err_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last_of_run: expected %0b, got %0b", want.last, out_tlast);
            err_count++;
          end
          if (out_tdata[23:21] !== 3'b000) begin
            $error("tdata padding: expected 0, got %0h", out_tdata[23:21]);
            err_count++;
          end
        end
      end
      rx_cycle <= rx_cycle + 1;
      if (hold_left > 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (hold_request && !hold_done && out_tvalid) begin
        // long back-pressure so the block fills and stalls its input
        hold_done  <= 1'b1;
        hold_left  <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        case (rx_cycle[6:5])
          2'd0:    out_tready <= 1'b1;
          2'd1:    out_tready <= 1'($urandom_range(1));
          2'd2:    out_tready <= ($urandom_range(3) == 0);
          default: out_tready <= rx_cycle[0];
        endcase
      end
    end
  end

  // watchdog on cycles without any transfer
  int idle_cycles = 0;

  always @(posedge clk) begin : watchdog
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic [12:0] pid;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default registers; first byte unmarked, payload ahead of any start is dropped
    push_header(1'b0, 13'd0, 1'b0, AFC_PAY_ONLY);
    push_byte(8'h11, 1'b0);
    // start with odd first payload byte, no frame open so no fill
    push_header(1'b1, 13'd0, 1'b1, AFC_PAY_ONLY);
    push_byte(8'h00, 1'b0);
    push_byte(8'hA1, 1'b0);
    // start after an empty adaptation field: fill run, even sync, payload
    push_header(1'b1, 13'd0, 1'b1, AFC_ADAPT_PAY);
    push_byte(8'h00, 1'b0);
    push_byte(8'h3C, 1'b0);
    push_byte(8'hFE, 1'b0);
    // adaptation-only packet is dropped
    push_header(1'b1, 13'd0, 1'b0, AFC_ADAPT_ONLY);
    push_byte(8'hFF, 1'b0);
    wait_drained();

    // highest PID, one-byte frames, zero fill
    write_reg(REG_WANTED_PID, 32'h1FFF);
    write_reg(REG_FRAME_LEN, 32'd1);
    write_reg(REG_FILL_BYTE, 32'h00);
    push_random_stream(13'h1FFF, 30);
    wait_drained();

    // short frames, all-ones fill, long receiver hold-off mid phase
    pid = 13'($urandom);
    write_reg(REG_WANTED_PID, {19'd0, pid});
    write_reg(REG_FRAME_LEN, 32'd20);
    write_reg(REG_FILL_BYTE, 32'hFF);
    push_random_stream(pid, 40);
    hold_request = 1'b1;
    wait_drained();

    // longest frame; a short frame then a second start gives a long fill run
    pid = 13'($urandom);
    write_reg(REG_WANTED_PID, {19'd0, pid});
    write_reg(REG_FRAME_LEN, 32'd8191);
    push_header(1'b1, pid, 1'b1, AFC_PAY_ONLY);
    push_byte(8'h00, 1'b0);
    repeat (6) push_byte(8'($urandom), 1'b0);
    push_header(1'b1, pid, 1'b1, AFC_PAY_ONLY);
    push_byte(8'h00, 1'b0);
    repeat (2) push_byte(8'($urandom), 1'b0);
    wait_drained();

    // PID zero, mid-size frames, random fill
    write_reg(REG_WANTED_PID, 32'd0);
    write_reg(REG_FRAME_LEN, $urandom_range(30, 60));
    write_reg(REG_FILL_BYTE, $urandom_range(255));
    push_random_stream(13'd0, 35);
    wait_drained();

    if (err_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

/* ts_pid_payload_to_eti_frames.f */
sv/tspe_pkg.sv
sv/tspe_parser.sv
sv/tspe_fifo.sv
sv/tspe_emitter.sv
sv/ts_pid_payload_to_eti_frames.sv
tb/ts_pid_payload_to_eti_frames_tb.sv
